// ----- hdl/min_window_all_letters_macros.svh -----
// Assertion helpers shared by the design files.
// Each helper expects signals named clk and rst_n in the scope of its use.
`ifndef MIN_WINDOW_ALL_LETTERS_MACROS_SVH
`define MIN_WINDOW_ALL_LETTERS_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MWAL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MWAL_ASSERT_SAME(label, ante, cons, msg)
`define MWAL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/mwal_pkg.sv -----
`timescale 1ns / 1ps

package mwal_pkg;

    localparam int MAX_LEN     = 65536;
    localparam int NUM_LETTERS = 26;

    localparam int CHAR_W  = 8;
    localparam int START_W = 16;
    localparam int LEN_W   = 17;

    // Stored positions are always below MAX_LEN; the byte counter can reach MAX_LEN.
    localparam int POS_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = POS_W + 1;
    localparam int ADDR_W = $clog2(NUM_LETTERS);
    localparam int IDX_W  = $clog2(NUM_LETTERS + 1);

    localparam logic [NUM_LETTERS-1:0] ALL_LETTERS = '1;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_SEARCH,
        S_UPDATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              is_letter;
        logic [ADDR_W-1:0] idx;
    } letter_t;

    // Control of the shared minimum unit: load takes the first value, en compares.
    typedef struct packed {
        logic load;
        logic en;
    } min_ctrl_t;

    function automatic letter_t decode_letter(input logic [CHAR_W-1:0] c);
        letter_t       res;
        logic [CHAR_W-1:0] diff;
        res  = '0;
        diff = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            diff          = c - CHAR_UPPER_A;
            res.is_letter = 1'b1;
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            diff          = c - CHAR_LOWER_A;
            res.is_letter = 1'b1;
        end
        res.idx = diff[ADDR_W-1:0];
        return res;
    endfunction

endpackage

// ----- hdl/mwal_if.sv -----
`timescale 1ns / 1ps

interface mwal_text_if
    import mwal_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface mwal_result_if
    import mwal_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] window_start;
    logic [LEN_W-1:0]   window_length;
    logic               overflow;

    modport source (output valid, output found, output window_start,
                    output window_length, output overflow, input ready);
    modport sink (input valid, input found, input window_start,
                  input window_length, input overflow, output ready);
endinterface

// ----- hdl/min_window_all_letters.sv -----
`timescale 1ns / 1ps
`include "min_window_all_letters_macros.svh"

// Shortest window holding every letter of the alphabet, over a byte stream.
// The text channel takes one byte per request, with last_char marking the end
// of the text; letters are case-folded and every byte counts toward length.
// After the request with last_char set, one request on the result channel
// gives found, window_start, window_length (both 0 when nothing was found)
// and overflow (the text ran past MAX_LEN bytes; extra bytes are dropped).
// Each accepted byte goes through the take state, which also writes its position,
// and back to idle; if it is a letter and all 26 letters have been seen, a
// minimum search follows that reads the 26 last-seen positions one at a time
// out of a position RAM with a registered read into one shared comparator,
// then the length update. The text channel is ready only in idle.
// The result is presented the cycle after the final byte is processed and
// held until the receiver takes it; the text channel stays not ready while
// the result waits. Taking the result clears all state for the next text.
// Reset is asynchronous and returns the block to idle with counters, seen
// mask, best window and overflow cleared; the position RAM is not cleared,
// as no entry is read before it is written.
module min_window_all_letters
    import mwal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mwal_text_if.sink    text,
    mwal_result_if.source result
);

    state_t state_reg;
    state_t state_next;

    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;
    logic [CNT_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       pos_next;
    logic [NUM_LETTERS-1:0] seen_reg;
    logic [NUM_LETTERS-1:0] seen_next;
    logic [POS_W-1:0]       best_start_reg;
    logic [POS_W-1:0]       best_start_next;
    logic [CNT_W-1:0]       best_len_reg;
    logic [CNT_W-1:0]       best_len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;

    letter_t                dec;
    logic [NUM_LETTERS-1:0] letter_bit;
    logic                   take_ovf;
    logic                   take_search;
    logic [CNT_W-1:0]       span;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [POS_W-1:0]  ram_rdata;
    min_ctrl_t         min_ctrl;
    logic [POS_W-1:0]  min_val;

    assign dec        = decode_letter(char_reg);
    assign letter_bit = NUM_LETTERS'(1) << dec.idx;
    assign take_ovf   = pos_reg >= CNT_W'(MAX_LEN);
    assign take_search = !take_ovf && dec.is_letter && ((seen_reg | letter_bit) == ALL_LETTERS);
    assign span       = pos_reg - CNT_W'(min_val) + CNT_W'(1);

    mwal_ram #(
        .WIDTH (POS_W),
        .DEPTH (NUM_LETTERS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dec.idx),
        .wdata (pos_reg[POS_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mwal_min_unit u_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (min_ctrl),
        .value   (ram_rdata),
        .min_val (min_val)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (text.valid)
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                if (take_search)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = last_reg ? S_OUT : S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (idx_reg == IDX_W'(NUM_LETTERS))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = last_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and control outputs.
    always_comb
    begin
        char_next       = char_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;
        min_ctrl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (text.valid)
                begin
                    char_next = text.char_in;
                    last_next = text.last_char;
                end
            end
            S_TAKE:
            begin
                idx_next = '0;
                if (take_ovf)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (dec.is_letter)
                    begin
                        ram_we    = 1'b1;
                        seen_next = seen_reg | letter_bit;
                    end
                    // When a search follows, the position advances after the update.
                    if (!take_search)
                    begin
                        pos_next = pos_reg + CNT_W'(1);
                    end
                end
            end
            S_SEARCH:
            begin
                // Read data is registered, so entry k is compared when idx_reg is k + 1.
                if (idx_reg < IDX_W'(NUM_LETTERS))
                begin
                    ram_raddr = idx_reg[ADDR_W-1:0];
                end
                min_ctrl.load = idx_reg == IDX_W'(1);
                min_ctrl.en   = idx_reg != '0;
                idx_next      = idx_reg + IDX_W'(1);
            end
            S_UPDATE:
            begin
                if (best_len_reg == '0 || span < best_len_reg)
                begin
                    best_len_next   = span;
                    best_start_next = min_val;
                end
                pos_next = pos_reg + CNT_W'(1);
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    pos_next        = '0;
                    seen_next       = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    ovf_next        = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            seen_reg       <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            seen_reg       <= seen_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.ready           = state_reg == S_IDLE;
    assign result.valid         = state_reg == S_OUT;
    assign result.found         = best_len_reg != '0;
    assign result.window_start  = START_W'(best_start_reg);
    assign result.window_length = LEN_W'(best_len_reg);
    assign result.overflow      = ovf_reg;

    `MWAL_ASSERT_SAME(a_search_all_seen, state_reg == S_SEARCH, seen_reg == ALL_LETTERS, "search started before all letters were seen")
    `MWAL_ASSERT_SAME(a_ovf_saturated, ovf_reg, pos_reg == CNT_W'(MAX_LEN), "overflow set below the length limit")
    `MWAL_ASSERT_SAME(a_best_fits, best_len_reg != '0, (best_len_reg - CNT_W'(1)) <= pos_reg, "best window longer than the text")
    `MWAL_ASSERT_NEXT(a_search_ends, state_reg == S_SEARCH && idx_reg == IDX_W'(NUM_LETTERS), state_reg == S_UPDATE, "search did not end after the last entry")

endmodule

// ----- hdl/mwal_ram.sv -----
`timescale 1ns / 1ps

module mwal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/mwal_min_unit.sv -----
`timescale 1ns / 1ps
`include "min_window_all_letters_macros.svh"

module mwal_min_unit
    import mwal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  min_ctrl_t        ctrl,
    input  logic [POS_W-1:0] value,
    output logic [POS_W-1:0] min_val
);

    logic [POS_W-1:0] min_reg;
    logic [POS_W-1:0] min_next;

    always_comb
    begin
        min_next = min_reg;
        if (ctrl.load)
        begin
            min_next = value;
        end
        else if (ctrl.en && value < min_reg)
        begin
            min_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
    end

    assign min_val = min_reg;

    `MWAL_ASSERT_NEXT(a_min_never_grows, ctrl.en && !ctrl.load, min_reg <= $past(min_reg), "running minimum grew")
    `MWAL_ASSERT_NEXT(a_min_bounded, ctrl.en || ctrl.load, min_reg <= $past(value), "running minimum above compared value")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mwal_pkg::*;

    // Longest run of cycles with no request taken on either side before giving up.
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASE_BYTES = 330;
    localparam int PHASE_TEXTS = 8;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               overflow;
    } window_t;

    // One row of the directed table: txt repeated reps times, or the single
    // byte code when txt is empty; fin puts last_char on the final byte.
    typedef struct {
        string             txt;
        logic [CHAR_W-1:0] code;
        int                reps;
        bit                fin;
        bit                typed;
        window_t           want;
    } text_row_t;

    logic clk;
    logic rst_n;

    mwal_text_if   text_if();
    mwal_result_if result_if();

    min_window_all_letters u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    // Window tracker state.
    int unsigned            last_pos[NUM_LETTERS];
    logic [NUM_LETTERS-1:0] seen_mask = '0;
    int unsigned            byte_count = 0;
    int unsigned            best_start = 0;
    int unsigned            best_len = 0;
    bit                     overflowed = 1'b0;

    window_t           windows_pending[$];
    text_row_t         text_table[$];
    logic [CHAR_W-1:0] text_buf[$];

    int send_idle_pct = 14;
    int recv_idle_pct = 73;
    int mismatches    = 0;
    int bytes_sent    = 0;
    int texts_done    = 0;
    int windows_found = 0;
    int quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Feeds one byte into the tracker; returns 1 with the reported window at the end of a text.
    function automatic bit track_window(input logic [CHAR_W-1:0] c, input bit fin,
                                        output window_t r);
        int          idx;
        int unsigned least;
        int unsigned span;
        idx = -1;
        r   = '0;
        if (byte_count >= MAX_LEN)
        begin
            overflowed = 1'b1;
        end
        else
        begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                idx = int'(c - CHAR_UPPER_A);
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                idx = int'(c - CHAR_LOWER_A);
            if (idx >= 0)
            begin
                last_pos[idx]  = byte_count;
                seen_mask[idx] = 1'b1;
                if (seen_mask == ALL_LETTERS)
                begin
                    least = last_pos[0];
                    for (int k = 1; k < NUM_LETTERS; k++)
                        if (last_pos[k] < least)
                            least = last_pos[k];
                    span = byte_count - least + 1;
                    // Only a strictly shorter window replaces the best, so ties keep the earliest.
                    if (best_len == 0 || span < best_len)
                    begin
                        best_len   = span;
                        best_start = least;
                    end
                end
            end
            byte_count++;
        end
        if (!fin)
            return 1'b0;
        r.found    = (best_len != 0);
        r.start    = r.found ? best_start[START_W-1:0] : '0;
        r.length   = r.found ? best_len[LEN_W-1:0] : '0;
        r.overflow = overflowed;
        seen_mask  = '0;
        byte_count = 0;
        best_start = 0;
        best_len   = 0;
        overflowed = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_row(input string txt, input logic [CHAR_W-1:0] code,
                                    input int reps, input bit fin, input bit typed = 1'b0,
                                    input bit f = 1'b0, input int st = 0, input int ln = 0,
                                    input bit ov = 1'b0);
        text_row_t row;
        row.txt           = txt;
        row.code          = code;
        row.reps          = reps;
        row.fin           = fin;
        row.typed         = typed;
        row.want.found    = f;
        row.want.start    = st[START_W-1:0];
        row.want.length   = ln[LEN_W-1:0];
        row.want.overflow = ov;
        text_table = {text_table, row};
    endfunction

    function automatic logic [CHAR_W-1:0] letter_byte(input int k);
        logic [CHAR_W-1:0] base;
        base = ($urandom_range(0, 1) == 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + CHAR_W'(k);
    endfunction

    // Mostly texts that hold the alphabet, some that miss one letter, some pure noise.
    function automatic void build_random_text();
        int kind;
        int skip;
        int passes;
        int j;
        int t;
        int order[NUM_LETTERS];
        text_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            repeat ($urandom_range(1, 24))
                text_buf = {text_buf, CHAR_W'($urandom_range(0, 255))};
        end
        else
        begin
            skip   = (kind < 35) ? $urandom_range(0, NUM_LETTERS - 1) : -1;
            passes = ($urandom_range(0, 99) < 35) ? 2 : 1;
            repeat ($urandom_range(0, 4))
                text_buf = {text_buf, CHAR_W'($urandom_range(0, 255))};
            repeat (passes)
            begin
                for (int i = 0; i < NUM_LETTERS; i++)
                    order[i] = i;
                for (int i = NUM_LETTERS - 1; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    t        = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int i = 0; i < NUM_LETTERS; i++)
                begin
                    if (order[i] != skip)
                    begin
                        text_buf = {text_buf, letter_byte(order[i])};
                        if ($urandom_range(0, 99) < 15)
                            text_buf = {text_buf, CHAR_W'($urandom_range(0, 255))};
                    end
                end
            end
        end
    endfunction

    task automatic send_byte(input logic [CHAR_W-1:0] c, input bit fin, input bit typed,
                             input window_t want);
        window_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.char_in   <= c;
        text_if.last_char <= fin;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        bytes_sent++;
        if (track_window(c, fin, predicted))
        begin
            texts_done++;
            if (predicted.found)
                windows_found++;
            windows_pending = {windows_pending, (typed ? want : predicted)};
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        window_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (windows_pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: found %0d start %0d length %0d overflow %0d",
                         $time, result_if.found, result_if.window_start,
                         result_if.window_length, result_if.overflow);
            end
            else
            begin
                want = windows_pending.pop_front();
                check_field("found", want.found, result_if.found);
                check_field("window_start", want.start, result_if.window_start);
                check_field("window_length", want.length, result_if.window_length);
                check_field("overflow", want.overflow, result_if.overflow);
            end
        end
    end

    // Receiver side: random back-pressure on the result channel.
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request taken for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        text_row_t         row;
        int                n;
        int                phase_bytes;
        int                phase_texts;
        bit                fin;
        logic [CHAR_W-1:0] c;

        rst_n             <= 1'b0;
        text_if.valid     <= 1'b0;
        text_if.char_in   <= '0;
        text_if.last_char <= 1'b0;

        add_row("q", '0, 1, 1'b1, 1'b1, 1'b0, 0, 0, 1'b0);
        add_row("", 8'h00, 1, 1'b1, 1'b1, 1'b0, 0, 0, 1'b0);
        add_row("", 8'hFF, 1, 1'b1, 1'b1, 1'b0, 0, 0, 1'b0);
        add_row("ABCDEFGHIJKLMNOPQRSTUVWXYZ", '0, 1, 1'b1, 1'b1, 1'b1, 0, 26, 1'b0);
        // Every window in a doubled alphabet is 26 long; the first one must stay.
        add_row("abcdefghijklmnopqrstuvwxyz", '0, 2, 1'b1, 1'b1, 1'b1, 0, 26, 1'b0);
        // Bytes just outside the letter ranges, and high bytes whose low bits look like letters.
        add_row("@[`{", '0, 1, 1'b0);
        add_row("", 8'h80, 1, 1'b0);
        add_row("", 8'hC1, 1, 1'b0);
        add_row("", 8'hE1, 1, 1'b0);
        add_row("", 8'h7F, 1, 1'b0);
        add_row("The Quick Brown Fox Jumps Over The Lazy Dog", '0, 1, 1'b0);
        add_row("zyxwvutsrqponmlkjihgfedcba", '0, 1, 1'b1);
        // A spread-out window followed by a tighter one that has to replace it.
        add_row("a-b-c-d-e-f-g-h-i-j-k-l-m-n-o-p-q-r-s-t-u-v-w-x-y-z", '0, 1, 1'b0);
        add_row("abcdefghijklmnopqrstuvwxyz", '0, 1, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (text_table[t])
        begin
            row = text_table[t];
            n   = (row.txt.len() == 0) ? 1 : row.txt.len();
            for (int rep = 0; rep < row.reps; rep++)
            begin
                for (int i = 0; i < n; i++)
                begin
                    c   = (row.txt.len() == 0) ? row.code : row.txt[i];
                    fin = row.fin && rep == row.reps - 1 && i == n - 1;
                    send_byte(c, fin, row.typed, row.want);
                end
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
            recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
            phase_bytes   = 0;
            phase_texts   = 0;
            while (phase_bytes < PHASE_BYTES || phase_texts < PHASE_TEXTS)
            begin
                build_random_text();
                for (int i = 0; i < text_buf.size(); i++)
                    send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
                phase_bytes += text_buf.size();
                phase_texts++;
            end
        end
        text_if.valid <= 1'b0;

        while (windows_pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d texts (%0d bytes); %0d of them held a full alphabet.",
                 texts_done, bytes_sent, windows_found);
        $display("Included ties, mixed case, bytes next to the letter ranges and stalls.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
